// ===== sv/average_directional_index_top_macros.svh =====
// assertion macros for the adx block
`ifndef AVERAGE_DIRECTIONAL_INDEX_TOP_MACROS_SVH
`define AVERAGE_DIRECTIONAL_INDEX_TOP_MACROS_SVH
// implication checked on every edge outside reset
`define ADX_ASSERT_IMP(label, clk, rst_n, pre, post) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
		else $error("assertion failed");
// next-cycle implication
`define ADX_ASSERT_NEXT(label, clk, rst_n, pre, post) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
		else $error("assertion failed");
`endif

// ===== sv/adx_pkg.sv =====
// ----------------------------------------------------------------------------
// adx_pkg
// shared types and constants for the average directional index block
// ----------------------------------------------------------------------------
`default_nettype none
package adx_pkg;
	localparam int PRICE_BITS_DEF = 32;
	localparam int MAX_PERIOD_DEF = 255;
	localparam int PERIOD_W = 8;
	localparam int CNT_W = 10;
	localparam int ADX_W = 23;
	localparam int ACC_W = 32;
	localparam logic [CNT_W-1:0] CANDLE_CAP = 10'd1023;
	localparam logic [31:0] HUNDRED_Q16 = 32'd6553600;
	localparam logic [ADX_W-1:0] DI_CAP = 23'd8388607;

	typedef enum logic [3:0] {
		ST_IDLE, ST_SMOOTH, ST_SDIV, ST_DIP, ST_DIM, ST_DX, ST_ADXM, ST_ADXD, ST_OUT
	} adx_state_t;
endpackage
`default_nettype wire

// ===== sv/adx_if.sv =====
// ----------------------------------------------------------------------------
// adx_if
// valid/ready channel carrying a payload
// ----------------------------------------------------------------------------
`default_nettype none
interface adx_if #(parameter type T = logic) ();
	logic valid;
	logic ready;
	T     data;
	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

// ===== sv/average_directional_index_top.sv =====
// ----------------------------------------------------------------------------
// average_directional_index_top
// wilder adx over a stream of candles
// ----------------------------------------------------------------------------
// usage: candles enter on the in channel (high, low, close, start_series), one
// result (adx_value, adx_valid) leaves on the out channel for every candle.
// the user must write the period register on the cfg channel only while the
// block is idle; the block itself does not enforce this. each division runs
// one bit a cycle in a single shared restoring divider: the first candle of a
// series needs none, a warmup candle runs the three smoothing divisions, after
// warmup the di+, di- and dx divisions follow, and once the adx is formed the
// adx division as well. the back finishes one candle before it takes the next.
// a two-entry request queue lets the front keep taking candles while the back
// computes; a result waits in the output register until taken, the back then
// finishes the next candle and waits, the queue fills and in.ready drops.
// reset clears all running state and sets the period to 14.
// ----------------------------------------------------------------------------
`default_nettype none
module average_directional_index_top #(
	parameter int PRICE_BITS = adx_pkg::PRICE_BITS_DEF,
	parameter int MAX_PERIOD = adx_pkg::MAX_PERIOD_DEF
) (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic cfg_valid,
	output logic     cfg_ready,
	input wire logic [adx_pkg::PERIOD_W-1:0] cfg_data,
	input wire logic in_valid,
	output logic     in_ready,
	input wire logic [PRICE_BITS-1:0] high_price,
	input wire logic [PRICE_BITS-1:0] low_price,
	input wire logic [PRICE_BITS-1:0] close_price,
	input wire logic start_series,
	output logic     out_valid,
	input wire logic out_ready,
	output logic [adx_pkg::ADX_W-1:0] adx_value,
	output logic     adx_valid
);
	import adx_pkg::*;
	logic [PERIOD_W-1:0] period_q;
	logic q_valid, q_ready, q_first;
	logic [PRICE_BITS-1:0] q_tr, q_pdm, q_mdm;

	assign cfg_ready = 1'b1;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) period_q <= PERIOD_W'(14);
		else if (cfg_valid) period_q <= cfg_data;
	end

	adx_front #(.PRICE_BITS(PRICE_BITS)) u_front (
		.clk(clk), .arst_n(arst_n), .in_valid(in_valid), .in_ready(in_ready),
		.high_price(high_price), .low_price(low_price), .close_price(close_price),
		.start_series(start_series), .q_valid(q_valid), .q_ready(q_ready),
		.q_tr(q_tr), .q_pdm(q_pdm), .q_mdm(q_mdm), .q_first(q_first)
	);

	adx_back #(.PRICE_BITS(PRICE_BITS), .MAX_PERIOD(MAX_PERIOD)) u_back (
		.clk(clk), .arst_n(arst_n), .period(period_q), .q_valid(q_valid),
		.q_ready(q_ready), .q_tr(q_tr), .q_pdm(q_pdm), .q_mdm(q_mdm),
		.q_first(q_first), .out_valid(out_valid), .out_ready(out_ready),
		.adx_value(adx_value), .adx_valid(adx_valid)
	);
endmodule
`default_nettype wire

// ===== sv/adx_div.sv =====
// ----------------------------------------------------------------------------
// adx_div
// radix-2 restoring divider, one quotient bit per cycle
// ----------------------------------------------------------------------------
`default_nettype none
module adx_div #(
	parameter int NUM_W = 80,
	parameter int DEN_W = 48
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             start,
	input  wire logic [NUM_W-1:0] num,
	input  wire logic [DEN_W-1:0] den,
	output logic                  done,
	output logic [NUM_W-1:0]      quo
);
	localparam int CW = $clog2(NUM_W + 1);
	logic [CW-1:0]    cnt_q;
	logic             busy_q;
	logic [DEN_W:0]   rem_q;
	logic [NUM_W-1:0] q_q;
	logic [DEN_W-1:0] d_q;
	logic [DEN_W+1:0] sh;
	logic             ge;

	assign sh = {rem_q, q_q[NUM_W-1]};
	assign ge = sh >= {2'b0, d_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
			done   <= 1'b0;
		end else begin
			done <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= CW'(NUM_W);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == CW'(1)) begin
					busy_q <= 1'b0;
					done   <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			q_q   <= num;
			d_q   <= den;
		end else if (busy_q) begin
			rem_q <= ge ? (DEN_W+1)'(sh - {2'b0, d_q}) : sh[DEN_W:0];
			q_q   <= {q_q[NUM_W-2:0], ge};
		end
	end
	assign quo = q_q;
endmodule
`default_nettype wire

// ===== sv/adx_front.sv =====
// ----------------------------------------------------------------------------
// adx_front
// accepts candles, forms true range and directional moves, queues them
// ----------------------------------------------------------------------------
`default_nettype none
module adx_front #(
	parameter int PRICE_BITS = 32
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  in_valid,
	output logic                       in_ready,
	input  wire logic [PRICE_BITS-1:0] high_price,
	input  wire logic [PRICE_BITS-1:0] low_price,
	input  wire logic [PRICE_BITS-1:0] close_price,
	input  wire logic                  start_series,
	output logic                       q_valid,
	input  wire logic                  q_ready,
	output logic [PRICE_BITS-1:0]      q_tr,
	output logic [PRICE_BITS-1:0]      q_pdm,
	output logic [PRICE_BITS-1:0]      q_mdm,
	output logic                       q_first
);
	import adx_pkg::*;
	localparam int SW = PRICE_BITS + 1;
	logic [PRICE_BITS-1:0] ph_q, pl_q, pc_q;
	logic                  seen_q;
	logic [1:0]            cnt_q;
	logic                  wp_q, rp_q;
	logic [PRICE_BITS-1:0] tr_q [2];
	logic [PRICE_BITS-1:0] pd_q [2];
	logic [PRICE_BITS-1:0] md_q [2];
	logic                  fi_q [2];
	logic signed [SW-1:0]  hl, hc, lc, hd, ld, tr;
	logic                  acc, first;
	logic [PRICE_BITS-1:0] pdm, mdm;

	assign in_ready = cnt_q != 2'd2;
	assign acc      = in_valid && in_ready;
	assign first    = start_series || !seen_q;

	always_comb begin
		hl = $signed({1'b0, high_price}) - $signed({1'b0, low_price});
		hc = $signed({1'b0, high_price}) - $signed({1'b0, pc_q});
		lc = $signed({1'b0, low_price}) - $signed({1'b0, pc_q});
		hd = $signed({1'b0, high_price}) - $signed({1'b0, ph_q});
		ld = $signed({1'b0, pl_q}) - $signed({1'b0, low_price});
		if (hc < 0) hc = -hc;
		if (lc < 0) lc = -lc;
		tr = hl;
		if (hc > tr) tr = hc;
		if (lc > tr) tr = lc;
		// a negative high-low range never survives, as the close distances are absolute
		pdm = (hd > ld && hd > 0) ? hd[PRICE_BITS-1:0] : '0;
		mdm = (ld > hd && ld > 0) ? ld[PRICE_BITS-1:0] : '0;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seen_q <= 1'b0;
			cnt_q  <= '0;
			wp_q   <= 1'b0;
			rp_q   <= 1'b0;
			ph_q   <= '0;
			pl_q   <= '0;
			pc_q   <= '0;
		end else begin
			if (acc) begin
				seen_q <= 1'b1;
				wp_q   <= !wp_q;
				ph_q   <= high_price;
				pl_q   <= low_price;
				pc_q   <= close_price;
			end
			if (q_valid && q_ready) rp_q <= !rp_q;
			cnt_q <= cnt_q + {1'b0, acc} - {1'b0, q_valid && q_ready};
		end
	end

	always_ff @(posedge clk) begin
		if (acc) begin
			tr_q[wp_q] <= tr[PRICE_BITS-1:0];
			pd_q[wp_q] <= pdm;
			md_q[wp_q] <= mdm;
			fi_q[wp_q] <= first;
		end
	end

	assign q_valid = cnt_q != 2'd0;
	assign q_tr    = tr_q[rp_q];
	assign q_pdm   = pd_q[rp_q];
	assign q_mdm   = md_q[rp_q];
	assign q_first = fi_q[rp_q];
endmodule
`default_nettype wire

// ===== sv/adx_back.sv =====
// ----------------------------------------------------------------------------
// adx_back
// wilder smoothing, di, dx and adx sequencer around one shared divider
// ----------------------------------------------------------------------------
`default_nettype none
module adx_back #(
	parameter int PRICE_BITS = 32,
	parameter int MAX_PERIOD = 255
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic [adx_pkg::PERIOD_W-1:0]  period,
	input  wire logic                          q_valid,
	output logic                               q_ready,
	input  wire logic [PRICE_BITS-1:0]         q_tr,
	input  wire logic [PRICE_BITS-1:0]         q_pdm,
	input  wire logic [PRICE_BITS-1:0]         q_mdm,
	input  wire logic                          q_first,
	output logic                               out_valid,
	input  wire logic                          out_ready,
	output logic [adx_pkg::ADX_W-1:0]          adx_value,
	output logic                               adx_valid
);
	import adx_pkg::*;
	localparam int SW = PRICE_BITS + 16;
	localparam int NW = SW + 32;
	localparam logic [SW-1:0] SCAP = '1;

	adx_state_t st_q, st_d;
	logic [SW-1:0] sr_q, sp_q, sm_q, x_tr_q, x_p_q, x_m_q;
	logic [CNT_W-1:0] n_q, n_cur_q;
	logic [ACC_W-1:0] acc_q;
	logic [ADX_W-1:0] adx_q, dip_q, dim_q, out_v_q, out_adx_q;
	logic [PERIOD_W-1:0] p_q;
	logic [1:0] sel_q;
	logic [39:0] prod;
	logic out_ok_q, v_q, out_vld_q;
	logic div_start, div_done;
	logic [NW-1:0] div_num, div_quo;
	logic [SW-1:0] div_den;
	logic [PERIOD_W-1:0] p_eff;
	logic [CNT_W-1:0] two_p;
	logic [SW:0] ssum;
	logic [SW-1:0] sel_s, sel_x;
	logic [ADX_W:0] dsum, dsum_n;
	logic [ADX_W-1:0] diff, diff_n, qsat;
	logic [ACC_W:0] accsum;
	logic out_load;

	always_comb begin
		p_eff = period;
		if (p_eff == '0) p_eff = PERIOD_W'(1);
		if (32'(p_eff) > MAX_PERIOD) p_eff = PERIOD_W'(MAX_PERIOD);
	end

	assign two_p = {1'b0, p_q, 1'b0};
	assign dsum  = {1'b0, dip_q} + {1'b0, dim_q};
	assign diff  = (dip_q > dim_q) ? dip_q - dim_q : dim_q - dip_q;
	assign qsat  = (div_quo > NW'(DI_CAP)) ? DI_CAP : div_quo[ADX_W-1:0];
	// di- straight from the divider on the cycle it finishes
	assign dsum_n = {1'b0, dip_q} + {1'b0, qsat};
	assign diff_n = (dip_q > qsat) ? dip_q - qsat : qsat - dip_q;
	assign accsum = {1'b0, acc_q} + (ACC_W+1)'(out_v_q);
	assign prod   = (n_cur_q == two_p) ? 40'(acc_q)
		: 40'(adx_q) * 40'(p_q - 1'b1) + 40'(out_v_q);
	assign out_load = (st_q == ST_OUT) && (!out_ok_q || out_ready);

	always_comb begin
		case (sel_q)
			2'd0:    begin sel_s = sr_q; sel_x = x_tr_q; end
			2'd1:    begin sel_s = sp_q; sel_x = x_p_q;  end
			default: begin sel_s = sm_q; sel_x = x_m_q;  end
		endcase
		// base is s - s/p once past the warmup sum
		ssum = {1'b0, sel_s} + {1'b0, sel_x};
		if (n_cur_q > CNT_W'(p_q))
			ssum = {1'b0, sel_s - div_quo[SW-1:0]} + {1'b0, sel_x};
	end

	adx_div #(.NUM_W(NW), .DEN_W(SW)) u_div (
		.clk(clk), .arst_n(arst_n), .start(div_start), .num(div_num), .den(div_den),
		.done(div_done), .quo(div_quo)
	);

	always_comb begin
		st_d      = st_q;
		q_ready   = 1'b0;
		div_start = 1'b0;
		div_num   = NW'(sel_s);
		div_den   = SW'(p_q);
		case (st_q)
			ST_IDLE: begin
				q_ready = 1'b1;
				if (q_valid) st_d = ST_SMOOTH;
			end
			ST_SMOOTH: begin
				if (n_cur_q == '0) st_d = ST_OUT;
				else begin
					div_start = 1'b1;
					st_d = ST_SDIV;
				end
			end
			ST_SDIV: begin
				if (div_done && sel_q == 2'd2) begin
					if (n_cur_q >= CNT_W'(p_q)) begin
						if (sr_q == '0 && ssum[SW-1:0] == '0 && !ssum[SW]) st_d = ST_DX;
						else begin
							div_num   = NW'(sp_q) * NW'(HUNDRED_Q16);
							div_den   = sr_q;
							div_start = sr_q != '0;
							st_d      = ST_DIP;
						end
					end else st_d = ST_OUT;
				end else if (div_done) begin
					div_num   = NW'((sel_q == 2'd0) ? sp_q : sm_q);
					div_start = 1'b1;
				end
			end
			ST_DIP: begin
				div_num = NW'(sp_q) * NW'(HUNDRED_Q16);
				div_den = sr_q;
				if (sr_q == '0) st_d = ST_DX;
				else if (div_done) begin
					div_start = 1'b1;
					div_num   = NW'(sm_q) * NW'(HUNDRED_Q16);
					st_d      = ST_DIM;
				end
			end
			ST_DIM: begin
				div_num = NW'(diff_n) * NW'(HUNDRED_Q16);
				div_den = SW'(dsum_n);
				if (div_done) begin
					st_d = ST_DX;
					if (dsum_n != '0) div_start = 1'b1;
				end
			end
			ST_DX: begin
				if (div_done || dsum == '0 || sr_q == '0) st_d = ST_ADXM;
			end
			ST_ADXM: begin
				div_num = NW'(prod);
				if (n_cur_q >= two_p) begin
					div_start = 1'b1;
					st_d = ST_ADXD;
				end else st_d = ST_OUT;
			end
			ST_ADXD: if (div_done) st_d = ST_OUT;
			ST_OUT: if (!out_ok_q || out_ready) st_d = ST_IDLE;
			default: st_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= ST_IDLE; sr_q <= '0; sp_q <= '0; sm_q <= '0; n_q <= '0;
			acc_q <= '0; adx_q <= '0; out_ok_q <= 1'b0; v_q <= 1'b0; sel_q <= '0;
			p_q <= PERIOD_W'(14); n_cur_q <= '0; dip_q <= '0; dim_q <= '0;
			out_v_q <= '0; x_tr_q <= '0; x_p_q <= '0; x_m_q <= '0;
			out_adx_q <= '0; out_vld_q <= 1'b0;
		end else begin
			st_q <= st_d;
			// result register frees the back while the receiver stalls
			if (out_load) begin
				out_ok_q  <= 1'b1;
				out_adx_q <= v_q ? adx_q : '0;
				out_vld_q <= v_q;
			end else if (out_ok_q && out_ready) out_ok_q <= 1'b0;
			case (st_q)
				ST_IDLE: if (q_valid) begin
					p_q <= p_eff; sel_q <= '0; v_q <= 1'b0;
					x_tr_q <= SW'(q_tr); x_p_q <= SW'(q_pdm); x_m_q <= SW'(q_mdm);
					if (q_first) begin
						sr_q <= '0; sp_q <= '0; sm_q <= '0; acc_q <= '0; adx_q <= '0;
						n_cur_q <= '0; n_q <= CNT_W'(1);
					end else begin
						n_cur_q <= n_q;
						if (n_q != CANDLE_CAP) n_q <= n_q + 1'b1;
					end
				end
				ST_SDIV: if (div_done) begin
					case (sel_q)
						2'd0:    sr_q <= ssum[SW] ? SCAP : ssum[SW-1:0];
						2'd1:    sp_q <= ssum[SW] ? SCAP : ssum[SW-1:0];
						default: sm_q <= ssum[SW] ? SCAP : ssum[SW-1:0];
					endcase
					sel_q <= sel_q + 1'b1;
					dip_q <= '0; dim_q <= '0; out_v_q <= '0;
				end
				ST_DIP: if (div_done) dip_q <= qsat;
				ST_DIM: if (div_done) dim_q <= qsat;
				ST_DX: begin
					if (div_done) out_v_q <= (div_quo > NW'(HUNDRED_Q16)) ?
						ADX_W'(HUNDRED_Q16) : div_quo[ADX_W-1:0];
				end
				ST_ADXM: begin
					if (n_cur_q < two_p)
						acc_q <= accsum[ACC_W] ? '1 : accsum[ACC_W-1:0];
				end
				ST_ADXD: if (div_done) begin
					adx_q <= (div_quo > NW'(HUNDRED_Q16)) ? ADX_W'(HUNDRED_Q16)
						: div_quo[ADX_W-1:0];
					v_q <= 1'b1;
				end
				default: ;
			endcase
		end
	end

	assign out_valid = out_ok_q;
	assign adx_valid = out_vld_q;
	assign adx_value = out_adx_q;
endmodule
`default_nettype wire

// ===== sv/adx_checker.sv =====
// ----------------------------------------------------------------------------
// adx_checker
// port-level checks on the adx block
// ----------------------------------------------------------------------------
`default_nettype none
`include "average_directional_index_top_macros.svh"
module adx_checker (
	input wire logic        clk,
	input wire logic        arst_n,
	input wire logic        out_valid,
	input wire logic        out_ready,
	input wire logic [22:0] adx_value,
	input wire logic        adx_valid
);
	`ADX_ASSERT_IMP(a_zero_when_invalid, clk, arst_n, out_valid && !adx_valid, adx_value == 23'd0)
	`ADX_ASSERT_IMP(a_range, clk, arst_n, out_valid, adx_value <= 23'd6553600)
	`ADX_ASSERT_NEXT(a_hold, clk, arst_n, out_valid && !out_ready, out_valid && $stable(adx_value))
endmodule
bind average_directional_index_top adx_checker u_chk (
	.clk(clk), .arst_n(arst_n), .out_valid(out_valid), .out_ready(out_ready),
	.adx_value(adx_value), .adx_valid(adx_valid)
);
`default_nettype wire

// ===== sim/tb.sv =====
// ----------------------------------------------------------------------------
// tb
// self-checking bench for the wilder adx block: candles go in on a valid/ready
// channel, a scoreboard predicts every adx result and checks it in order
// ----------------------------------------------------------------------------
`default_nettype none

typedef struct packed {
	logic [31:0] high_price;
	logic [31:0] low_price;
	logic [31:0] close_price;
	logic        start_series;
} candle_t;

typedef struct packed {
	logic [22:0] adx_value;
	logic        adx_valid;
} adx_out_t;

class adx_scoreboard;
	bit [63:0] period;
	bit [63:0] prev_h, prev_l, prev_c;
	bit [63:0] sum_tr, sum_pdm, sum_mdm;
	bit [63:0] idx, dx_acc, adx_reg;
	adx_out_t  pending[$];
	int        mismatches;
	int        n_in;
	int        n_out;
	int        n_valid;

	function new();
		period = 14;
		clear();
		mismatches = 0;
		n_in = 0;
		n_out = 0;
		n_valid = 0;
	endfunction

	function void clear();
		prev_h = 0; prev_l = 0; prev_c = 0;
		sum_tr = 0; sum_pdm = 0; sum_mdm = 0;
		idx = 0; dx_acc = 0; adx_reg = 0;
	endfunction

	function bit [63:0] smooth(bit [63:0] s, bit [63:0] x, bit [63:0] n, bit [63:0] p);
		bit [63:0] base;
		bit [63:0] r;
		base = (n <= p) ? s : s - s / p;
		r = base + x;
		return (r > 64'hFFFF_FFFF_FFFF) ? 64'hFFFF_FFFF_FFFF : r;
	endfunction

	// floor(a * 100.0 in q16 / b), saturated
	function bit [63:0] scale_div(bit [63:0] a, bit [63:0] b, bit [63:0] cap);
		bit [127:0] q;
		q = ({64'd0, a} * 128'd6553600) / {64'd0, b};
		return (q > {64'd0, cap}) ? cap : q[63:0];
	endfunction

	function void note(candle_t c);
		bit [63:0] p, n, pdm, mdm, dx, dip, dim, diff;
		longint hl, hc, lc, hd, ld, tr;
		adx_out_t e;
		p = (period == 0) ? 1 : period;
		if (c.start_series)
			clear();
		n = idx;
		e = '0;
		if (n > 0) begin
			hl = longint'({32'd0, c.high_price}) - longint'({32'd0, c.low_price});
			hc = longint'({32'd0, c.high_price}) - longint'(prev_c);
			lc = longint'({32'd0, c.low_price}) - longint'(prev_c);
			hd = longint'({32'd0, c.high_price}) - longint'(prev_h);
			ld = longint'(prev_l) - longint'({32'd0, c.low_price});
			if (hc < 0) hc = -hc;
			if (lc < 0) lc = -lc;
			tr = hl;
			if (hc > tr) tr = hc;
			if (lc > tr) tr = lc;
			pdm = (hd > ld && hd > 0) ? hd : 0;
			mdm = (ld > hd && ld > 0) ? ld : 0;
			sum_tr = smooth(sum_tr, tr, n, p);
			sum_pdm = smooth(sum_pdm, pdm, n, p);
			sum_mdm = smooth(sum_mdm, mdm, n, p);
			if (n >= p) begin
				dx = 0;
				if (sum_tr != 0) begin
					dip = scale_div(sum_pdm, sum_tr, 64'd8388607);
					dim = scale_div(sum_mdm, sum_tr, 64'd8388607);
					diff = (dip > dim) ? dip - dim : dim - dip;
					if (dip + dim != 0)
						dx = scale_div(diff, dip + dim, 64'd6553600);
				end
				if (n < 2 * p) begin
					dx_acc = dx_acc + dx;
					if (dx_acc > 64'hFFFF_FFFF) dx_acc = 64'hFFFF_FFFF;
				end else begin
					if (n == 2 * p)
						adx_reg = dx_acc / p;
					else
						adx_reg = (adx_reg * (p - 1) + dx) / p;
					if (adx_reg > 64'd6553600) adx_reg = 64'd6553600;
					e.adx_value = adx_reg[22:0];
					e.adx_valid = 1'b1;
				end
			end
		end
		prev_h = c.high_price;
		prev_l = c.low_price;
		prev_c = c.close_price;
		if (idx < 1023) idx++;
		pending.push_back(e);
		n_in++;
	endfunction

	function void check(adx_out_t got);
		adx_out_t e;
		n_out++;
		if (pending.size() == 0) begin
			mismatches++;
			if (mismatches <= 10)
				$display("unexpected result adx=%0d valid=%0b", got.adx_value, got.adx_valid);
			return;
		end
		e = pending.pop_front();
		if (got.adx_valid) n_valid++;
		if (got.adx_value !== e.adx_value || got.adx_valid !== e.adx_valid) begin
			mismatches++;
			if (mismatches <= 10)
				$display("result %0d: expected adx=%0d valid=%0b, got adx=%0d valid=%0b",
					n_out, e.adx_value, e.adx_valid, got.adx_value, got.adx_valid);
		end
	endfunction
endclass

module tb;
	logic clk = 1'b0;
	logic arst_n = 1'b0;
	longint cyc = 0;
	int idle_since = 0;
	bit pressed = 0;
	bit [31:0] walk = 32'd100000;

	adx_if #(.T(candle_t))   in_ch ();
	adx_if #(.T(adx_out_t))  out_ch ();
	adx_if #(.T(logic [7:0])) cfg_ch ();

	adx_scoreboard sb = new();

	always #1 clk = ~clk;

	average_directional_index_top u_top (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_valid(cfg_ch.valid),
		.cfg_ready(cfg_ch.ready),
		.cfg_data(cfg_ch.data),
		.in_valid(in_ch.valid),
		.in_ready(in_ch.ready),
		.high_price(in_ch.data.high_price),
		.low_price(in_ch.data.low_price),
		.close_price(in_ch.data.close_price),
		.start_series(in_ch.data.start_series),
		.out_valid(out_ch.valid),
		.out_ready(out_ch.ready),
		.adx_value(out_ch.data.adx_value),
		.adx_valid(out_ch.data.adx_valid)
	);

	initial begin
		in_ch.valid = 1'b0;
		in_ch.data = '0;
		cfg_ch.valid = 1'b0;
		cfg_ch.data = '0;
		out_ch.ready = 1'b0;
	end

	// no idling on either side in this window
	function automatic bit calm();
		return cyc >= 60000 && cyc < 110000;
	endfunction

	always @(posedge clk) begin
		cyc <= cyc + 1;
		if (arst_n) begin
			if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)
					|| (cfg_ch.valid && cfg_ch.ready))
				idle_since <= 0;
			else
				idle_since <= idle_since + 1;
			if (in_ch.valid && in_ch.ready)
				sb.note(in_ch.data);
			if (out_ch.valid && out_ch.ready)
				sb.check(out_ch.data);
		end
	end

	always @(posedge clk) begin
		if (idle_since >= 20000) begin
			$display("watchdog: no progress");
			$display("== FAIL ==");
			$finish;
		end
	end

	// receiver with random stalls and one long hold-off
	initial begin
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			if (!pressed && sb.n_in >= 30) begin
				pressed = 1;
				out_ch.ready = 1'b0;
				repeat (3000) @(negedge clk);
			end
			out_ch.ready = calm() ? 1'b1 : ($urandom_range(0, 99) >= 11);
		end
	end

	task automatic send_candle(candle_t c);
		@(negedge clk);
		if (!calm() && $urandom_range(0, 99) < 11) begin
			in_ch.valid = 1'b0;
			repeat ($urandom_range(1, 8)) @(negedge clk);
		end
		in_ch.valid = 1'b1;
		in_ch.data = c;
		do @(posedge clk); while (!in_ch.ready);
	endtask

	task automatic write_period(logic [7:0] v);
		@(negedge clk);
		in_ch.valid = 1'b0;
		while (sb.pending.size() != 0) @(posedge clk);
		repeat (600) @(posedge clk);
		@(negedge clk);
		cfg_ch.valid = 1'b1;
		cfg_ch.data = v;
		do @(posedge clk); while (!cfg_ch.ready);
		sb.period = v;
		@(negedge clk);
		cfg_ch.valid = 1'b0;
	endtask

	function automatic candle_t mk(bit [31:0] h, bit [31:0] l, bit [31:0] c, bit s);
		candle_t r;
		r.high_price = h;
		r.low_price = l;
		r.close_price = c;
		r.start_series = s;
		return r;
	endfunction

	// mostly consistent candles on a random walk, some noise and flat bars
	function automatic candle_t rand_candle();
		int sel;
		bit [31:0] up, dn, mv;
		bit [31:0] h, l;
		sel = $urandom_range(0, 99);
		if (sel < 8)
			return mk($urandom, $urandom, $urandom, $urandom_range(0, 99) < 3);
		if (sel < 13)
			return mk(walk, walk, walk, 1'b0);
		mv = $urandom >> $urandom_range(4, 31);
		if ($urandom_range(0, 1)) walk = walk + mv; else walk = walk - mv;
		up = $urandom >> $urandom_range(6, 31);
		dn = $urandom >> $urandom_range(6, 31);
		h = (walk > 32'hFFFF_FFFF - up) ? 32'hFFFF_FFFF : walk + up;
		l = (walk < dn) ? 32'd0 : walk - dn;
		return mk(h, l, l + (h - l) / 32'($urandom_range(1, 4)), sel < 15);
	endfunction

	task automatic run_series(logic [7:0] per, int count);
		write_period(per);
		send_candle(mk(walk, walk, walk, 1'b1));
		repeat (count - 1) send_candle(rand_candle());
	endtask

	initial begin
		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// directed: extremes, inverted bars, pure up and down moves
		send_candle(mk(32'd0, 32'd0, 32'd0, 1'b0));
		send_candle(mk(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b0));
		send_candle(mk(32'd0, 32'd0, 32'd0, 1'b0));
		send_candle(mk(32'hFFFF_FFFF, 32'd0, 32'h8000_0000, 1'b0));
		send_candle(mk(32'd10, 32'hFFFF_FFF0, 32'd5, 1'b0));
		send_candle(mk(32'd100, 32'd50, 32'hFFFF_FFFF, 1'b0));
		send_candle(mk(32'd1000, 32'd900, 32'd950, 1'b1));
		for (int i = 0; i < 8; i++)
			send_candle(mk(32'd1010 + i * 20, 32'd905 + i * 20, 32'd960 + i * 20, 1'b0));
		for (int i = 0; i < 8; i++)
			send_candle(mk(32'd1100 - i * 30, 32'd1000 - i * 40, 32'd1050 - i * 35, 1'b0));
		send_candle(mk(32'd800, 32'd600, 32'd700, 1'b0));
		send_candle(mk(32'd900, 32'd500, 32'd700, 1'b0));

		run_series(8'd1, 30);
		run_series(8'd0, 20);
		run_series(8'd2, 30);
		run_series(8'd7, 40);
		run_series(8'd255, 530);
		run_series(8'd3, 30);

		@(negedge clk);
		in_ch.valid = 1'b0;
		while (sb.pending.size() != 0) @(posedge clk);
		repeat (600) @(posedge clk);

		$display("%0d candles in, %0d results checked (%0d with adx valid)",
			sb.n_in, sb.n_out, sb.n_valid);
		$display("periods 14, 1, 0, 2, 7, 255, 3; %0d mismatches", sb.mismatches);
		if (sb.mismatches == 0 && sb.pending.size() == 0)
			$display("== PASS ==");
		else
			$display("== FAIL ==");
		$finish;
	end
endmodule
`default_nettype wire
